// ===== hw/rtl/mmpd_pkg.sv =====
package mmpd_pkg;

	// fixed field widths
	localparam int IDX_W  = 4;
	localparam int PW     = 4;
	localparam int POS_W  = 6;
	localparam int TS_W   = 16;
	localparam int PS_W   = 24;
	localparam int NS_W   = 5;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int REG_SEL_BIT = 2;
	localparam logic REG_IDX_NUM_STATES = 1'b0;
	localparam logic [NS_W-1:0] NUM_STATES_RST = 5'd16;

	// request opcodes
	typedef enum logic [1:0] {
		OP_WR_TRANS = 2'd0,
		OP_WR_INIT  = 2'd1,
		OP_DECODE   = 2'd2,
		OP_NONE     = 2'd3
	} opcode_t;

	// score limits
	localparam logic signed [TS_W-1:0] TS_NEG_INF = 16'sh8000;
	localparam logic signed [PS_W-1:0] PS_FLOOR   = -24'sd32768;
	localparam logic signed [PS_W-1:0] PS_CEIL    = 24'sd8388607;

	// table write bundle
	typedef struct packed {
		logic                   we_trans;
		logic                   we_init;
		logic [IDX_W-1:0]       row;
		logic [IDX_W-1:0]       col;
		logic signed [TS_W-1:0] data;
	} tbl_wr_t;

	// path buffer write bundle
	typedef struct packed {
		logic             we;
		logic [POS_W-1:0] pos;
		logic [PW-1:0]    state;
	} path_wr_t;

	// saturating add, minus infinity absorbs
	function automatic logic signed [PS_W-1:0] sat_add(
		input logic signed [PS_W-1:0] a,
		input logic signed [TS_W-1:0] b
	);
		logic signed [PS_W:0] sum;
		sum = $signed({a[PS_W-1], a}) + $signed({{(PS_W-TS_W+1){b[TS_W-1]}}, b});
		if (a <= PS_FLOOR || b == TS_NEG_INF)
			return PS_FLOOR;
		if (sum < PS_FLOOR)
			return PS_FLOOR;
		if (sum > PS_CEIL)
			return PS_CEIL;
		return sum[PS_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/mmpd_tables.sv =====
module mmpd_tables #(
	parameter int MAX_STATES = 16,
	localparam int SW = $clog2(MAX_STATES)
) (
	input  logic                             clk,
	input  mmpd_pkg::tbl_wr_t                wr,
	input  logic [2*SW-1:0]                  trans_raddr,
	input  logic [SW-1:0]                    init_raddr,
	output logic signed [mmpd_pkg::TS_W-1:0] trans_rdata,
	output logic signed [mmpd_pkg::TS_W-1:0] init_rdata
);
	import mmpd_pkg::*;

	logic signed [TS_W-1:0] trans_mem [2**(2*SW)];
	logic signed [TS_W-1:0] init_mem  [2**SW];
	logic signed [TS_W-1:0] trans_rdata_q;
	logic signed [TS_W-1:0] init_rdata_q;
	logic                   row_ok;
	logic                   col_ok;

	// writes beyond the built size are dropped
	assign row_ok = 32'(wr.row) < MAX_STATES;
	assign col_ok = 32'(wr.col) < MAX_STATES;

	always_ff @(posedge clk) begin
		if (wr.we_trans && row_ok && col_ok) begin
			trans_mem[{SW'(wr.row), SW'(wr.col)}] <= wr.data;
		end
		trans_rdata_q <= trans_mem[trans_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.we_init && row_ok) begin
			init_mem[SW'(wr.row)] <= wr.data;
		end
		init_rdata_q <= init_mem[init_raddr];
	end

	assign trans_rdata = trans_rdata_q;
	assign init_rdata  = init_rdata_q;

endmodule

// ===== hw/rtl/mmpd_core.sv =====
module mmpd_core #(
	parameter int MAX_STATES = 16,
	parameter int PATH_LEN   = 4,
	localparam int SW = $clog2(MAX_STATES)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [mmpd_pkg::IDX_W-1:0]       start_state,
	input  logic [mmpd_pkg::NS_W-1:0]        num_states,
	output logic [2*SW-1:0]                  trans_raddr,
	output logic [SW-1:0]                    init_raddr,
	input  logic signed [mmpd_pkg::TS_W-1:0] trans_rdata,
	input  logic signed [mmpd_pkg::TS_W-1:0] init_rdata,
	output logic                             busy,
	output logic                             done,
	output mmpd_pkg::path_wr_t               path_wr
);
	import mmpd_pkg::*;

	localparam int PLW = $clog2(PATH_LEN);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_INIT    = 11'b000_0000_0010,
		S_DR1     = 11'b000_0000_0100,
		S_ACS     = 11'b000_0000_1000,
		S_DR2     = 11'b000_0001_0000,
		S_FIN     = 11'b000_0010_0000,
		S_DR3     = 11'b000_0100_0000,
		S_BT_TOP  = 11'b000_1000_0000,
		S_BT_RD   = 11'b001_0000_0000,
		S_BT_WR   = 11'b010_0000_0000,
		S_BT_LAST = 11'b100_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		K_INIT = 2'd0,
		K_ACS  = 2'd1,
		K_FIN  = 2'd2
	} kind_t;

	state_t            st_q;
	logic [IDX_W-1:0]  s0_q;
	logic              s0_oob_q;
	logic [SW-1:0]     nm1_q;
	logic [SW-1:0]     nm1_d;
	logic [SW-1:0]     i_q;
	logic [SW-1:0]     j_q;
	logic [PLW-1:0]    t_q;
	logic              cur_q;
	logic [SW-1:0]     cst_q;

	// read stage
	logic              vld_s1;
	kind_t             kind_s1;
	logic [SW-1:0]     i_s1;
	logic [SW-1:0]     j_s1;
	logic              first_s1;
	logic              last_s1;

	logic signed [PS_W-1:0] best_q;
	logic [SW-1:0]          bidx_q;

	// path score and back pointer memories
	logic signed [PS_W-1:0] ps_mem [2**(SW+1)];
	logic [SW-1:0]          bp_mem [2**(PLW+SW)];
	logic signed [PS_W-1:0] ps_rdata_q;
	logic [SW-1:0]          bp_rdata_q;
	logic [SW:0]            ps_raddr;
	logic [SW:0]            ps_waddr;
	logic                   ps_re;
	logic                   ps_we;
	logic signed [PS_W-1:0] ps_wdata;
	logic                   bp_we;

	logic                   issue;
	logic signed [PS_W-1:0] init_ext;
	logic signed [TS_W-1:0] tr_first;
	logic signed [PS_W-1:0] val_init;
	logic signed [PS_W-1:0] val_acs;
	logic signed [PS_W-1:0] cand;
	logic                   take;
	logic signed [PS_W-1:0] best_d;
	logic [SW-1:0]          bidx_d;

	// clamp the state count to 1..MAX_STATES
	always_comb begin
		if (num_states == '0) begin
			nm1_d = '0;
		end else if (32'(num_states) > MAX_STATES) begin
			nm1_d = SW'(MAX_STATES - 1);
		end else begin
			nm1_d = SW'(num_states - NS_W'(1));
		end
	end

	// read addresses
	assign trans_raddr = (st_q == S_INIT) ? {SW'(s0_q), i_q} : {i_q, j_q};
	assign init_raddr  = i_q;
	assign ps_raddr    = {cur_q, i_q};
	assign ps_re       = (st_q == S_ACS) || (st_q == S_FIN);
	assign issue       = (st_q == S_INIT) || ps_re;

	// add, compare, select on the read data
	assign init_ext = {{(PS_W-TS_W){init_rdata[TS_W-1]}}, init_rdata};
	assign tr_first = s0_oob_q ? TS_NEG_INF : trans_rdata;
	assign val_init = sat_add(init_ext, tr_first);
	assign val_acs  = sat_add(ps_rdata_q, trans_rdata);
	assign cand     = (kind_s1 == K_FIN) ? ps_rdata_q : val_acs;
	assign take     = first_s1 || (cand > best_q);
	assign best_d   = take ? cand : best_q;
	assign bidx_d   = take ? i_s1 : bidx_q;

	always_comb begin
		ps_we    = 1'b0;
		ps_waddr = {1'b0, i_s1};
		ps_wdata = val_init;
		bp_we    = 1'b0;
		if (vld_s1 && kind_s1 == K_INIT) begin
			ps_we = 1'b1;
		end else if (vld_s1 && kind_s1 == K_ACS && last_s1) begin
			ps_we    = 1'b1;
			ps_waddr = {~cur_q, j_s1};
			ps_wdata = best_d;
			bp_we    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ps_we) begin
			ps_mem[ps_waddr] <= ps_wdata;
		end
		ps_rdata_q <= ps_mem[ps_raddr];
	end

	always_ff @(posedge clk) begin
		if (bp_we) begin
			bp_mem[{t_q, j_s1}] <= bidx_d;
		end
		bp_rdata_q <= bp_mem[{t_q, cst_q}];
	end

	// read stage payload
	always_ff @(posedge clk) begin
		kind_s1  <= (st_q == S_INIT) ? K_INIT : ((st_q == S_ACS) ? K_ACS : K_FIN);
		i_s1     <= i_q;
		j_s1     <= j_q;
		first_s1 <= (i_q == '0);
		last_s1  <= (i_q == nm1_q);
		if (vld_s1 && kind_s1 != K_INIT) begin
			best_q <= best_d;
			bidx_q <= bidx_d;
		end
		if (st_q == S_IDLE && start) begin
			s0_q     <= start_state;
			s0_oob_q <= 32'(start_state) >= MAX_STATES;
			nm1_q    <= nm1_d;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			vld_s1 <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
			t_q    <= '0;
			cur_q  <= 1'b0;
			cst_q  <= '0;
		end else begin
			vld_s1 <= issue;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						i_q   <= '0;
						cur_q <= 1'b0;
						st_q  <= S_INIT;
					end
				end
				S_INIT: begin
					if (i_q == nm1_q) begin
						i_q  <= '0;
						st_q <= S_DR1;
					end else begin
						i_q <= i_q + SW'(1);
					end
				end
				S_DR1: begin
					i_q <= '0;
					j_q <= '0;
					t_q <= PLW'(2);
					st_q <= (PATH_LEN > 2) ? S_ACS : S_FIN;
				end
				S_ACS: begin
					if (i_q == nm1_q) begin
						i_q <= '0;
						if (j_q == nm1_q) begin
							j_q  <= '0;
							st_q <= S_DR2;
						end else begin
							j_q <= j_q + SW'(1);
						end
					end else begin
						i_q <= i_q + SW'(1);
					end
				end
				S_DR2: begin
					cur_q <= ~cur_q;
					if (t_q == PLW'(PATH_LEN - 1)) begin
						st_q <= S_FIN;
					end else begin
						t_q  <= t_q + PLW'(1);
						st_q <= S_ACS;
					end
				end
				S_FIN: begin
					if (i_q == nm1_q) begin
						i_q  <= '0;
						st_q <= S_DR3;
					end else begin
						i_q <= i_q + SW'(1);
					end
				end
				S_DR3: begin
					st_q <= S_BT_TOP;
				end
				S_BT_TOP: begin
					cst_q <= bidx_q;
					t_q   <= PLW'(PATH_LEN - 1);
					st_q  <= (PATH_LEN > 2) ? S_BT_RD : S_BT_LAST;
				end
				S_BT_RD: begin
					st_q <= S_BT_WR;
				end
				S_BT_WR: begin
					cst_q <= bp_rdata_q;
					t_q   <= t_q - PLW'(1);
					st_q  <= (t_q == PLW'(2)) ? S_BT_LAST : S_BT_RD;
				end
				S_BT_LAST: begin
					st_q <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// path buffer writes, last position first, start state at the end
	always_comb begin
		path_wr = '0;
		case (st_q)
			S_BT_TOP: begin
				path_wr.we    = 1'b1;
				path_wr.pos   = POS_W'(PATH_LEN - 1);
				path_wr.state = PW'(bidx_q);
			end
			S_BT_WR: begin
				path_wr.we    = 1'b1;
				path_wr.pos   = POS_W'(t_q) - POS_W'(1);
				path_wr.state = PW'(bp_rdata_q);
			end
			S_BT_LAST: begin
				path_wr.we    = 1'b1;
				path_wr.pos   = '0;
				path_wr.state = s0_q;
			end
			default: begin
				path_wr = '0;
			end
		endcase
	end

	assign busy = (st_q != S_IDLE);
	assign done = (st_q == S_BT_LAST);

	a_s1_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> st_q != S_IDLE)
		else $error("read stage busy while sequencer idle");

	a_ps_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(ps_we && ps_re) |-> ps_waddr != ps_raddr)
		else $error("path score read and write hit the same entry");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> st_q == S_IDLE)
		else $error("decode started while busy");

endmodule

// ===== hw/rtl/mmpd_out.sv =====
module mmpd_out #(
	parameter int PATH_LEN = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mmpd_pkg::path_wr_t              path_wr,
	input  logic                            done,
	output logic                            emitting,
	output logic                            path_valid,
	input  logic                            path_stall,
	output logic [mmpd_pkg::PW-1:0]         path_state,
	output logic [mmpd_pkg::POS_W-1:0]      position,
	output logic                            last
);
	import mmpd_pkg::*;

	localparam int PLW = $clog2(PATH_LEN);

	logic [PW-1:0]    path_mem [PATH_LEN];
	logic [PW-1:0]    rdata_q;
	logic [PLW-1:0]   rp_q;
	logic             emit_q;
	logic             infl_q;
	logic [PLW-1:0]   pos_s1;
	logic             last_s1;
	logic             vld_q;
	logic [PW-1:0]    state_q;
	logic [POS_W-1:0] pos_q;
	logic             last_q;
	logic             issue;
	logic             rp_last;

	assign rp_last = (rp_q == PLW'(PATH_LEN - 1));
	// read only when the output register is free by the time data arrives
	assign issue   = emit_q && !infl_q && (!vld_q || !path_stall);

	always_ff @(posedge clk) begin
		if (path_wr.we) begin
			path_mem[PLW'(path_wr.pos)] <= path_wr.state;
		end
		rdata_q <= path_mem[rp_q];
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pos_s1  <= rp_q;
			last_s1 <= rp_last;
		end
		if (infl_q) begin
			state_q <= rdata_q;
			pos_q   <= POS_W'(pos_s1);
			last_q  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
			infl_q <= 1'b0;
			rp_q   <= '0;
			vld_q  <= 1'b0;
		end else begin
			infl_q <= issue;
			if (done) begin
				emit_q <= 1'b1;
				rp_q   <= '0;
			end else if (issue) begin
				if (rp_last) begin
					emit_q <= 1'b0;
				end else begin
					rp_q <= rp_q + PLW'(1);
				end
			end
			if (infl_q) begin
				vld_q <= 1'b1;
			end else if (!path_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

	assign emitting   = emit_q;
	assign path_valid = vld_q;
	assign path_state = state_q;
	assign position   = pos_q;
	assign last       = last_q;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		infl_q |=> vld_q)
		else $error("read data not presented");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!emit_q && !infl_q))
		else $error("new path while previous still being read");

	a_more_to_come: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && !last_q) |-> emit_q)
		else $error("path ended without last flag");

endmodule

// ===== hw/rtl/markov_max_path_decoder_top.sv =====
// Markov max-path decoder: most likely state path of PATH_LEN positions
// through a chain of up to MAX_STATES states, log-domain scores in Q7.8.
// request channel (item_valid / item_stall): opcode 0 writes one transition
//   score (row_index -> col_index), opcode 1 writes one initial score, opcode 2
//   starts a decode from start_state, opcode 3 is dropped. Load requests can
//   follow back to back.
// result channel (path_valid / path_stall): a decode gives PATH_LEN results,
//   position 0 (the start state) first, last set on the final position.
// apb: num_states at byte address 0; user writes it only while the block idles, unchecked
// a decode (num_states clamped to 1..MAX_STATES) runs an init pass,
//   PATH_LEN-2 add-compare-select passes, a final search and a backtrack, one
//   path buffer read per result with no overlap; add-compare-select does one
//   predecessor per cycle through the single path score memory read port
// item_stall stays high from the decode request until the last result has
//   been read out of the path buffer; the last result may still wait in the
//   output register while the next request is taken
// a stalled result holds; the path buffer read waits for the output register
// reset clears the control state and sets num_states to 16; score tables are
//   undefined until loaded and must be written before decoding
module markov_max_path_decoder_top #(
	parameter int MAX_STATES = 16,
	parameter int PATH_LEN   = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// apb
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mmpd_pkg::APB_AW-1:0]        paddr,
	input  logic [mmpd_pkg::APB_DW-1:0]        pwdata,
	output logic [mmpd_pkg::APB_DW-1:0]        prdata,
	output logic                               pready,
	// request channel
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [1:0]                         opcode,
	input  logic [mmpd_pkg::IDX_W-1:0]         row_index,
	input  logic [mmpd_pkg::IDX_W-1:0]         col_index,
	input  logic signed [mmpd_pkg::TS_W-1:0]   score,
	input  logic [mmpd_pkg::IDX_W-1:0]         start_state,
	// result channel
	output logic                               path_valid,
	input  logic                               path_stall,
	output logic [mmpd_pkg::PW-1:0]            path_state,
	output logic [mmpd_pkg::POS_W-1:0]         position,
	output logic                               last
);
	import mmpd_pkg::*;

	localparam int SW = $clog2(MAX_STATES);

	logic [NS_W-1:0]        num_states_q;
	logic                   cfg_wr;
	logic                   req_acc;
	tbl_wr_t                tbl_wr;
	logic                   start;
	logic [2*SW-1:0]        trans_raddr;
	logic [SW-1:0]          init_raddr;
	logic signed [TS_W-1:0] trans_rdata;
	logic signed [TS_W-1:0] init_rdata;
	logic                   core_busy;
	logic                   done;
	path_wr_t               path_wr;
	logic                   emitting;

	// register file: one register, byte lanes ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[REG_SEL_BIT] == REG_IDX_NUM_STATES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= NUM_STATES_RST;
		end else if (cfg_wr) begin
			num_states_q <= pwdata[NS_W-1:0];
		end
	end

	assign prdata = (paddr[REG_SEL_BIT] == REG_IDX_NUM_STATES) ? APB_DW'(num_states_q) : '0;

	// no request is taken while a decode is in flight or its path is read out
	assign item_stall = core_busy || emitting;
	assign req_acc    = item_valid && !item_stall;

	always_comb begin
		tbl_wr.we_trans = req_acc && (opcode == OP_WR_TRANS);
		tbl_wr.we_init  = req_acc && (opcode == OP_WR_INIT);
		tbl_wr.row      = row_index;
		tbl_wr.col      = col_index;
		tbl_wr.data     = score;
	end

	assign start = req_acc && (opcode == OP_DECODE);

	mmpd_tables #(
		.MAX_STATES (MAX_STATES)
	) u_tables (
		.clk         (clk),
		.wr          (tbl_wr),
		.trans_raddr (trans_raddr),
		.init_raddr  (init_raddr),
		.trans_rdata (trans_rdata),
		.init_rdata  (init_rdata)
	);

	// score recursion and backtrack
	mmpd_core #(
		.MAX_STATES (MAX_STATES),
		.PATH_LEN   (PATH_LEN)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.start_state (start_state),
		.num_states  (num_states_q),
		.trans_raddr (trans_raddr),
		.init_raddr  (init_raddr),
		.trans_rdata (trans_rdata),
		.init_rdata  (init_rdata),
		.busy        (core_busy),
		.done        (done),
		.path_wr     (path_wr)
	);

	// path buffer and output register
	mmpd_out #(
		.PATH_LEN (PATH_LEN)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.path_wr    (path_wr),
		.done       (done),
		.emitting   (emitting),
		.path_valid (path_valid),
		.path_stall (path_stall),
		.path_state (path_state),
		.position   (position),
		.last       (last)
	);

endmodule
